/* rtl/sfc_pkg.sv */
package sfc_pkg;

  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int WAIT_W   = 19;
  localparam int KIND_W   = 3;
  localparam int LEN_W    = 7;
  localparam int RELOAD_W = 16;

  localparam int RX_MAX_DEF = 64;
  localparam logic [RELOAD_W-1:0] IDLE_RELOAD_RST = 16'd500;

  // SLIP special bytes
  localparam logic [BYTE_W-1:0] B_END     = 8'hC0;
  localparam logic [BYTE_W-1:0] B_ESC     = 8'hDB;
  localparam logic [BYTE_W-1:0] B_ESC_END = 8'hDC;
  localparam logic [BYTE_W-1:0] B_ESC_ESC = 8'hDD;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND_BYTE = 3'd0,
    CMD_SEND_END  = 3'd1,
    CMD_RX_START  = 3'd2,
    CMD_RX_BYTE   = 3'd3,
    CMD_TICK      = 3'd4
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    K_TX      = 3'd0,
    K_RXDATA  = 3'd1,
    K_DONE    = 3'd2,
    K_BADESC  = 3'd3,
    K_TIMEOUT = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [LEN_W-1:0]   rx_count;
    logic               last;
  } result_t;

  // up to two results produced by one item
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

/* rtl/sfc_if.sv */
interface sfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfc_pkg::CMD_W-1:0]     cmd;
  logic [sfc_pkg::BYTE_W-1:0]    data_byte;
  logic [sfc_pkg::WAIT_W-1:0]    wait_ticks;

  modport source (output valid, cmd, data_byte, wait_ticks, input ready);
  modport sink (input valid, cmd, data_byte, wait_ticks, output ready);
endinterface

interface sfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfc_pkg::KIND_W-1:0]    kind;
  logic [sfc_pkg::BYTE_W-1:0]    out_byte;
  logic [sfc_pkg::LEN_W-1:0]     rx_count;
  logic                          last;

  modport source (output valid, kind, out_byte, rx_count, last, input ready);
  modport sink (input valid, kind, out_byte, rx_count, last, output ready);
endinterface

/* rtl/sfc_core.sv */
module sfc_core #(
  parameter int RX_MAX = sfc_pkg::RX_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfc_pkg::RELOAD_W-1:0]   cfg_wdata,
  sfc_in_if.sink                         in_ch,
  input  logic                           room,
  output sfc_pkg::push_t                 push
);
  import sfc_pkg::*;

  localparam int LEN_CAP_I = (RX_MAX > 127) ? 127 : RX_MAX;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);

  logic                held;
  cmd_t                h_cmd;
  logic [BYTE_W-1:0]   h_byte;
  logic [WAIT_W-1:0]   h_wait;
  logic                fire;

  logic [RELOAD_W-1:0] idle_reload;
  logic                escape_pending, escape_pending_next;
  logic                rx_active, rx_active_next;
  logic [WAIT_W-1:0]   wait_count, wait_count_next;
  logic [LEN_W-1:0]    rx_length, rx_length_next;

  logic                v0, v1;
  kind_t               k0, k1;
  logic [BYTE_W-1:0]   b0, b1;
  logic [LEN_W-1:0]    len_bump;
  logic [WAIT_W-1:0]   wait_dec;

  assign in_ch.ready = !held || room;
  assign fire        = held && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ch.ready) begin
      held <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      h_cmd  <= cmd_t'(in_ch.cmd);
      h_byte <= in_ch.data_byte;
      h_wait <= in_ch.wait_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_reload    <= IDLE_RELOAD_RST;
      escape_pending <= 1'b0;
      rx_active      <= 1'b0;
      wait_count     <= '0;
      rx_length      <= '0;
    end else begin
      if (cfg_we) begin
        idle_reload <= cfg_wdata;
      end
      if (fire) begin
        escape_pending <= escape_pending_next;
        rx_active      <= rx_active_next;
        wait_count     <= wait_count_next;
        rx_length      <= rx_length_next;
      end
    end
  end

  assign len_bump = (rx_length < LEN_CAP) ? rx_length + LEN_W'(1) : rx_length;
  assign wait_dec = (wait_count != '0) ? wait_count - WAIT_W'(1) : wait_count;

  always_comb begin
    escape_pending_next = escape_pending;
    rx_active_next      = rx_active;
    wait_count_next     = wait_count;
    rx_length_next      = rx_length;
    v0 = 1'b0;
    v1 = 1'b0;
    k0 = K_TX;
    k1 = K_TX;
    b0 = '0;
    b1 = '0;
    case (h_cmd)
      CMD_SEND_BYTE: begin
        v0 = 1'b1;
        if (h_byte == B_END || h_byte == B_ESC) begin
          v1 = 1'b1;
          b0 = B_ESC;
          b1 = (h_byte == B_END) ? B_ESC_END : B_ESC_ESC;
        end else begin
          b0 = h_byte;
        end
      end
      CMD_SEND_END: begin
        v0 = 1'b1;
        b0 = B_END;
      end
      CMD_RX_START: begin
        escape_pending_next = 1'b0;
        rx_length_next      = '0;
        wait_count_next     = h_wait;
        rx_active_next      = (h_wait != '0);
        if (h_wait == '0) begin
          v0 = 1'b1;
          k0 = K_TIMEOUT;
        end
      end
      CMD_RX_BYTE: begin
        if (rx_active) begin
          wait_count_next = WAIT_W'(idle_reload);
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            v0 = 1'b1;
            if (h_byte == B_ESC_ESC || h_byte == B_ESC_END) begin
              rx_length_next = len_bump;
              k0 = K_RXDATA;
              b0 = (h_byte == B_ESC_ESC) ? B_ESC : B_END;
            end else begin
              rx_active_next = 1'b0;
              k0 = K_BADESC;
              b0 = h_byte;
            end
          end else if (h_byte == B_END) begin
            rx_length_next = len_bump;
            rx_active_next = 1'b0;
            v0 = 1'b1;
            k0 = K_DONE;
            b0 = B_END;
          end else if (h_byte == B_ESC) begin
            escape_pending_next = 1'b1;
          end else begin
            rx_length_next = len_bump;
            v0 = 1'b1;
            k0 = K_RXDATA;
            b0 = h_byte;
          end
          // frame still open with a zero reload times out right away
          if (rx_active_next && idle_reload == '0) begin
            rx_active_next      = 1'b0;
            escape_pending_next = 1'b0;
            if (v0) begin
              v1 = 1'b1;
              k1 = K_TIMEOUT;
            end else begin
              v0 = 1'b1;
              k0 = K_TIMEOUT;
            end
          end
        end
      end
      CMD_TICK: begin
        if (rx_active) begin
          wait_count_next = wait_dec;
          if (wait_dec == '0) begin
            rx_active_next      = 1'b0;
            escape_pending_next = 1'b0;
            v0 = 1'b1;
            k0 = K_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push.cnt         = fire ? {v1, v0 & !v1} : 2'd0;
    push.r0.kind     = k0;
    push.r0.out_byte = b0;
    push.r0.rx_count = rx_length_next;
    push.r0.last     = !v1;
    push.r1.kind     = k1;
    push.r1.out_byte = b1;
    push.r1.rx_count = rx_length_next;
    push.r1.last     = 1'b1;
  end

endmodule

/* rtl/sfc_resq.sv */
module sfc_resq (
  input  logic           clk,
  input  logic           rst,
  input  sfc_pkg::push_t push,
  output logic           room,
  sfc_out_if.source      out_ch
);
  import sfc_pkg::*;

  result_t    mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic       pop;
  result_t    head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = (count <= 3'd2);
  assign head = mem[rp];

  assign out_ch.valid    = (count != 3'd0);
  assign out_ch.kind     = head.kind;
  assign out_ch.out_byte = head.out_byte;
  assign out_ch.rx_count = head.rx_count;
  assign out_ch.last     = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.cnt;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, push.cnt} - {2'b0, pop};
    end
    if (push.cnt != 2'd0) begin
      mem[wp] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp + 2'd1] <= push.r1;
    end
  end

endmodule

/* rtl/slip_frame_codec.sv */
// Datapath: the first result of an item passes the input register, then the
// result queue, before it is offered on out_ch.
// Throughput: one item per cycle while the result queue has room; an item
// giving two results (escaped byte, byte plus timeout) holds the single output port for both.
// Reset (rst, synchronous): receiver idle, counters cleared, idle_reload = 500.
module slip_frame_codec #(
  parameter int RX_MAX = sfc_pkg::RX_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sfc_pkg::RELOAD_W-1:0]  cfg_wdata,
  sfc_in_if.sink                        in_ch,
  sfc_out_if.source                     out_ch
);
  import sfc_pkg::*;

  push_t push;
  logic  room;

  sfc_core #(
    .RX_MAX(RX_MAX)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .room     (room),
    .push     (push)
  );

  sfc_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .out_ch(out_ch)
  );

`ifndef SYNTHESIS
  a_push_cnt: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd3)
    else $error("more than two results pushed for one item");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !room |-> push.cnt == 2'd0)
    else $error("results pushed with no queue room");

  a_timeout_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind == K_TIMEOUT |-> out_ch.last && out_ch.out_byte == '0)
    else $error("timeout result is not final");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("output valid right after reset");
`endif

endmodule
